// ===== hw/rtl/rhp_pkg.sv =====
// Shared types, constants and lookup tables for the radiotap header parser.
`timescale 1ns / 1ps
`default_nettype none
package rhp_pkg;

  localparam int PositionBits = 16;
  localparam int NumFields    = 22;
  localparam int IdxW         = $clog2(NumFields);
  localparam int OutDataW     = 56;

  localparam logic [IdxW-1:0] FieldChannel = IdxW'(3);
  localparam logic [IdxW-1:0] FieldSignal  = IdxW'(5);
  localparam int              FieldSkip    = 18;

  // alignment minus one, per present bit
  localparam logic [2:0] FldAlignMask [NumFields] = '{
    3'd7, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd1
  };

  localparam logic [3:0] FldSize [NumFields] = '{
    4'd8, 4'd1, 4'd1, 4'd4, 4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd0, 4'd3, 4'd8, 4'd12
  };

  typedef enum logic [4:0] {
    PhLength  = 5'b00001,
    PhPresent = 5'b00010,
    PhWalk    = 5'b00100,
    PhDone    = 5'b01000,
    PhInvalid = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                 walk;
    logic [IdxW-1:0]      idx;
    logic [15:0]          off;
    logic [NumFields-1:0] bits;
  } pick_t;

  typedef struct packed {
    logic        sig_present;
    logic [7:0]  sig;
    logic [7:0]  chan;
    logic [15:0] freq;
    logic [15:0] len;
  } result_t;

  // frequency in MHz to channel number; x/5 via x*205>>10, exact below 1024
  function automatic logic [7:0] chan_map(input logic [15:0] f);
    logic [9:0]  x;
    logic [17:0] p;
    logic [7:0]  ch;
    x  = '0;
    ch = '0;
    if (f == 16'd2484) begin
      ch = 8'd14;
    end else if (f inside {[16'd2412:16'd2472]}) begin
      x  = 10'(f - 16'd2407);
      p  = 18'(x) * 18'd205;
      ch = p[17:10];
    end else if (f inside {[16'd5000:16'd5900]}) begin
      x  = 10'(f - 16'd5000);
      p  = 18'(x) * 18'd205;
      ch = p[17:10];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rhp_field_pick.sv =====
// Next present field selection: priority encode, align, and header-length bound.
`timescale 1ns / 1ps
`default_nettype none
module rhp_field_pick (
  input  wire logic [rhp_pkg::NumFields-1:0] bits_i,
  input  wire logic [15:0]                   off_i,
  input  wire logic [15:0]                   hdr_len_i,
  output rhp_pkg::pick_t                     pick_o
);

  logic [rhp_pkg::NumFields-1:0] mask;
  logic                          found;
  logic [rhp_pkg::IdxW-1:0]      idx;
  logic [2:0]                    al_mask;
  logic [16:0]                   aligned;
  logic [17:0]                   fld_end;

  // zero-size fields are skipped
  assign mask = bits_i & ~(rhp_pkg::NumFields'(1) << rhp_pkg::FieldSkip);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int j = rhp_pkg::NumFields - 1; j >= 0; j--) begin
      if (mask[j]) begin
        found = 1'b1;
        idx   = rhp_pkg::IdxW'(j);
      end
    end
  end

  assign al_mask = rhp_pkg::FldAlignMask[idx];
  assign aligned = ({1'b0, off_i} + 17'(al_mask)) & ~17'(al_mask);
  assign fld_end = 18'(aligned) + 18'(rhp_pkg::FldSize[idx]);

  always_comb begin
    pick_o.walk = found && (fld_end <= 18'(hdr_len_i));
    pick_o.idx  = idx;
    pick_o.off  = pick_o.walk ? aligned[15:0] : off_i;
    pick_o.bits = found ? bits_i : '0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rhp_parser.sv =====
// Per-byte parse state and next-state logic; forms the result on the last byte.
`timescale 1ns / 1ps
`default_nettype none
module rhp_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output rhp_pkg::result_t res_o
);

  localparam int PB = rhp_pkg::PositionBits;
  localparam int NF = rhp_pkg::NumFields;

  logic [PB-1:0]            pos_q, pos_d;
  logic [15:0]              hl_q, hl_d;
  logic [NF-1:0]            bits_q, bits_d;
  logic [NF-1:0]            word_q, word_d;
  rhp_pkg::phase_e          phase_q, phase_d;
  logic [15:0]              next_q, next_d;
  logic [rhp_pkg::IdxW-1:0] idx_q, idx_d;
  logic [15:0]              freq_q, freq_d;
  logic [7:0]               sig_q, sig_d;
  logic                     seen_q, seen_d;

  logic                     at_max;
  logic [15:0]              pos16;
  logic [15:0]              diff;
  logic                     first;
  logic [3:0]               fsize;
  logic                     pick_en;
  logic [NF-1:0]            pick_bits;
  logic [15:0]              pick_off;
  rhp_pkg::pick_t           pick;
  logic [PB-1:0]            len_item;
  logic [15:0]              len16;
  logic                     ok;

  assign at_max = (pos_q == {PB{1'b1}});
  assign pos16  = 16'(pos_q);
  assign diff   = pos16 - next_q;
  assign first  = (next_q == 16'd4);
  assign fsize  = rhp_pkg::FldSize[idx_q];

  rhp_field_pick u_pick (
    .bits_i    (pick_bits),
    .off_i     (pick_off),
    .hdr_len_i (hl_q),
    .pick_o    (pick)
  );

  always_comb begin
    hl_d      = hl_q;
    bits_d    = bits_q;
    word_d    = word_q;
    phase_d   = phase_q;
    next_d    = next_q;
    idx_d     = idx_q;
    freq_d    = freq_q;
    sig_d     = sig_q;
    seen_d    = seen_q;
    pick_en   = 1'b0;
    pick_bits = bits_q;
    pick_off  = next_q + 16'd4;
    if (!at_max) begin
      case (phase_q)
        rhp_pkg::PhLength: begin
          if (pos16 == 16'd2) begin
            hl_d = {8'h00, data_i};
          end else if (pos16 == 16'd3) begin
            hl_d = {data_i, hl_q[7:0]};
            if (hl_d < 16'd8) begin
              phase_d = rhp_pkg::PhInvalid;
            end else begin
              phase_d = rhp_pkg::PhPresent;
              next_d  = 16'd4;
            end
          end
        end
        rhp_pkg::PhPresent: begin
          if (diff[1:0] != 2'd3) begin
            if (first) begin
              case (diff[1:0])
                2'd0:    word_d[7:0]   = data_i;
                2'd1:    word_d[15:8]  = data_i;
                default: word_d[21:16] = data_i[5:0];
              endcase
            end
          end else begin
            if (first) bits_d = word_q;
            next_d    = next_q + 16'd4;
            pick_bits = first ? word_q : bits_q;
            pick_off  = next_q + 16'd4;
            if (!data_i[7] || ({1'b0, next_q} + 17'd8 > {1'b0, hl_q})) pick_en = 1'b1;
          end
        end
        rhp_pkg::PhWalk: begin
          if (pos16 >= next_q) begin
            if (idx_q == rhp_pkg::FieldChannel && diff == 16'd0) freq_d = {8'h00, data_i};
            if (idx_q == rhp_pkg::FieldChannel && diff == 16'd1) freq_d = {data_i, freq_q[7:0]};
            if (idx_q == rhp_pkg::FieldSignal && diff == 16'd0) begin
              sig_d  = data_i;
              seen_d = 1'b1;
            end
            if (diff + 16'd1 >= 16'(fsize)) begin
              next_d    = next_q + 16'(fsize);
              bits_d    = bits_q & ~(NF'(1) << idx_q);
              pick_bits = bits_d;
              pick_off  = next_q + 16'(fsize);
              pick_en   = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (pick_en) begin
        bits_d = pick.bits;
        if (pick.walk) begin
          phase_d = rhp_pkg::PhWalk;
          idx_d   = pick.idx;
          next_d  = pick.off;
        end else begin
          phase_d = rhp_pkg::PhDone;
        end
      end
    end
  end

  assign pos_d    = at_max ? pos_q : pos_q + PB'(1);
  assign len_item = at_max ? pos_q : pos_q + PB'(1);
  assign len16    = 16'(len_item);

  assign ok = (len16 >= 16'd8) && (phase_d != rhp_pkg::PhInvalid) &&
              (phase_d != rhp_pkg::PhLength) && (hl_d >= 16'd8) && (hl_d <= len16);

  always_comb begin
    res_o.len         = ok ? hl_d : '0;
    res_o.freq        = ok ? freq_d : '0;
    res_o.chan        = ok ? rhp_pkg::chan_map(freq_d) : '0;
    res_o.sig         = (ok && seen_d) ? sig_d : '0;
    res_o.sig_present = ok && seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hl_q    <= '0;
      bits_q  <= '0;
      word_q  <= '0;
      phase_q <= rhp_pkg::PhLength;
      next_q  <= '0;
      idx_q   <= '0;
      freq_q  <= '0;
      sig_q   <= '0;
      seen_q  <= 1'b0;
    end else if (item_valid_i) begin
      if (last_i) begin
        pos_q   <= '0;
        hl_q    <= '0;
        bits_q  <= '0;
        word_q  <= '0;
        phase_q <= rhp_pkg::PhLength;
        next_q  <= '0;
        idx_q   <= '0;
        freq_q  <= '0;
        sig_q   <= '0;
        seen_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        hl_q    <= hl_d;
        bits_q  <= bits_d;
        word_q  <= word_d;
        phase_q <= phase_d;
        next_q  <= next_d;
        idx_q   <= idx_d;
        freq_q  <= freq_d;
        sig_q   <= sig_d;
        seen_q  <= seen_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/radiotap_header_parser_top.sv =====
// Top level of the radiotap header parser: input register, parser, result register.
// The tlast item passes the input register; the result register loads when that item is processed.
// Throughput: one byte item per cycle; one result per packet, at its last byte.
// Non-last items keep flowing while a result waits; a tlast item then waits for it.
// Reset (rst_ni low, asynchronous) clears parse state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
module radiotap_header_parser_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // data_byte
  input  wire logic                         s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // radiotap_length[15:0], frequency_mhz[31:16], channel_number[39:32],
  // signal_level[47:40], signal_present[48], zero fill[55:49]
  output logic [rhp_pkg::OutDataW-1:0]      m_axis_tdata
);

  logic             in_valid_q;
  logic [7:0]       in_data_q;
  logic             in_last_q;
  logic             out_free;
  logic             proc;
  rhp_pkg::result_t res;
  rhp_pkg::result_t out_q;
  logic             out_valid_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  rhp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (proc),
    .data_i       (in_data_q),
    .last_i       (in_last_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rhp_pkg::OutDataW'(out_q);

endmodule
`default_nettype wire

// ===== hw/rtl/rhp_checker.sv =====
// Port-level checks for the radiotap header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rhp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         s_axis_tlast,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [rhp_pkg::OutDataW-1:0] m_axis_tdata
);

  logic       last_in;
  logic       res_out;
  logic [1:0] pend_q;

  assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  // packets whose last item went in but whose result has not been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (last_in && !res_out) begin
      pend_q <= pend_q + 2'd1;
    end else if (!last_in && res_out) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_res_has_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without a finished packet");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more packets in flight than register stages");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 |-> m_axis_tdata[55:16] == '0)
    else $error("fields set on invalid header");

  a_no_sig_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:40] == 8'd0)
    else $error("signal value without signal field");

endmodule

bind radiotap_header_parser_top rhp_checker u_rhp_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the radiotap header parser: directed and random packets.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned POS_MAX     = (1 << rhp_pkg::PositionBits) - 1;
  localparam int unsigned NUM_FLD     = 22;
  localparam int unsigned CH_FIELD    = 3;
  localparam int unsigned SIG_FIELD   = 5;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 8;

  localparam int unsigned FIELD_ALIGN [NUM_FLD] = '{
    8, 1, 1, 2, 2, 1, 1, 2, 2, 2, 1, 1, 1, 1, 2, 2, 1, 1, 1, 1, 4, 2
  };
  localparam int unsigned FIELD_SIZE [NUM_FLD] = '{
    8, 1, 1, 4, 2, 1, 1, 2, 2, 2, 1, 1, 1, 1, 2, 2, 1, 1, 0, 3, 8, 12
  };
  localparam logic [15:0] FREQ_EDGES [15] = '{
    16'd2484, 16'd2412, 16'd2472, 16'd2417, 16'd5000, 16'd5900, 16'd5180, 16'd2411,
    16'd2473, 16'd2483, 16'd2485, 16'd4999, 16'd5901, 16'd0, 16'hFFFF
  };

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rhp_pkg::OutDataW-1:0]  m_axis_tdata;

  radiotap_header_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // parser shadow state
  int unsigned       pos_q, hdr_len, bits_left, word_acc, field_off, field_idx;
  int unsigned       freq_val, sig_val;
  bit                sig_seen;
  rhp_pkg::phase_e   phase;

  rhp_pkg::result_t  hdr_summary_q [$];
  rhp_pkg::result_t  want, got;
  logic [7:0]        pkt_bytes [$];

  int unsigned tx_idle_pct, rx_idle_pct;
  int unsigned rx_hold_req, rx_hold_left;
  int unsigned n_bytes, n_packets, n_checked, mismatches, stall_cycles;

  function automatic void clear_parser();
    pos_q     = 0;
    hdr_len   = 0;
    bits_left = 0;
    word_acc  = 0;
    phase     = rhp_pkg::PhLength;
    field_off = 0;
    field_idx = 0;
    freq_val  = 0;
    sig_val   = 0;
    sig_seen  = 1'b0;
  endfunction

  function automatic logic [7:0] channel_of(input int unsigned f);
    if (f == 2484) return 8'd14;
    if (f >= 2412 && f <= 2472) return 8'((f - 2407) / 5);
    if (f >= 5000 && f <= 5900) return 8'((f - 5000) / 5);
    return 8'd0;
  endfunction

  // next present field of the first word if it fits, else done
  function automatic void next_field();
    int unsigned b, al, a;
    bit          scan;
    scan = 1'b1;
    while (scan && bits_left != 0) begin
      b = 0;
      while (b < NUM_FLD && ((bits_left >> b) & 1) == 0) b++;
      if (b >= NUM_FLD) begin
        scan = 1'b0;
      end else if (FIELD_SIZE[b] == 0) begin
        bits_left &= ~(32'd1 << b);
      end else begin
        al = FIELD_ALIGN[b];
        a  = (field_off + al - 1) & ~(al - 1);
        if (a + FIELD_SIZE[b] > hdr_len) begin
          phase = rhp_pkg::PhDone;
          return;
        end
        field_idx = b;
        field_off = a;
        phase     = rhp_pkg::PhWalk;
        return;
      end
    end
    bits_left = 0;
    phase     = rhp_pkg::PhDone;
  endfunction

  function automatic void parse_byte(input int unsigned i, input int unsigned d);
    int unsigned k, b;
    bit          first;
    case (phase)
      rhp_pkg::PhLength: begin
        if (i == 2) begin
          hdr_len = d;
        end else if (i == 3) begin
          hdr_len |= d << 8;
          if (hdr_len < 8) begin
            phase = rhp_pkg::PhInvalid;
          end else begin
            phase     = rhp_pkg::PhPresent;
            field_off = 4;
          end
        end
      end
      rhp_pkg::PhPresent: begin
        k     = i - field_off;
        first = (field_off == 4);
        if (k < 3) begin
          if (first) word_acc |= d << (8 * k);
        end else begin
          if (first) bits_left = word_acc & 32'h003F_FFFF;
          field_off += 4;
          if ((d & 32'h80) == 0 || field_off + 4 > hdr_len) next_field();
        end
      end
      rhp_pkg::PhWalk: begin
        if (i >= field_off) begin
          k = i - field_off;
          b = field_idx;
          if (b >= NUM_FLD) begin
            phase = rhp_pkg::PhDone;
          end else begin
            if (b == CH_FIELD && k == 0) freq_val = d;
            if (b == CH_FIELD && k == 1) freq_val |= d << 8;
            if (b == SIG_FIELD && k == 0) begin
              sig_val  = d;
              sig_seen = 1'b1;
            end
            if (k + 1 >= FIELD_SIZE[b]) begin
              field_off += FIELD_SIZE[b];
              bits_left &= ~(32'd1 << b);
              next_field();
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] data, input logic last);
    int unsigned      i, pkt_len;
    bit               ok;
    rhp_pkg::result_t r;
    i = pos_q & POS_MAX;
    if (i < POS_MAX) begin
      parse_byte(i, data);
      pkt_len = i + 1;
      pos_q   = i + 1;
    end else begin
      pkt_len = POS_MAX;
    end
    if (last) begin
      ok = pkt_len >= 8 && phase != rhp_pkg::PhInvalid && phase != rhp_pkg::PhLength &&
           hdr_len >= 8 && hdr_len <= pkt_len;
      r = '0;
      if (ok) begin
        r.len  = 16'(hdr_len);
        r.freq = 16'(freq_val);
        r.chan = channel_of(freq_val & 32'hFFFF);
        if (sig_seen) begin
          r.sig         = 8'(sig_val);
          r.sig_present = 1'b1;
        end
      end
      hdr_summary_q = {hdr_summary_q, r};
      clear_parser();
    end
  endfunction

  function automatic void cmp_field(input string name, input int unsigned exp_v,
                                    input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (hdr_summary_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = hdr_summary_q[0];
        hdr_summary_q.delete(0);
        got  = m_axis_tdata[$bits(rhp_pkg::result_t)-1:0];
        cmp_field("radiotap_length", want.len, got.len);
        cmp_field("frequency_mhz", want.freq, got.freq);
        cmp_field("channel_number", want.chan, got.chan);
        cmp_field("signal_level", want.sig, got.sig);
        cmp_field("signal_present", want.sig_present, got.sig_present);
        cmp_field("zero fill", 0, m_axis_tdata[rhp_pkg::OutDataW-1:$bits(rhp_pkg::result_t)]);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(d, l);
    n_bytes++;
  endtask

  task automatic send_pkt();
    foreach (pkt_bytes[k]) send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
    n_packets++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (hdr_summary_q.size() != 0);
  endtask

  task automatic set_hdr_len(input int unsigned n);
    pkt_bytes[2] = 8'(n);
    pkt_bytes[3] = 8'(n >> 8);
  endtask

  task automatic add_payload(input int unsigned n);
    repeat (n) pkt_bytes = {pkt_bytes, 8'($urandom)};
  endtask

  // well-formed header: present words, then every field of the first word, aligned
  task automatic build_header(input logic [31:0] present, input int n_words,
                              input logic [15:0] freq, input logic [7:0] sig);
    logic [31:0] w;
    pkt_bytes.delete();
    pkt_bytes = {pkt_bytes, 8'h00};
    pkt_bytes = {pkt_bytes, 8'($urandom)};
    pkt_bytes = {pkt_bytes, 8'h00};
    pkt_bytes = {pkt_bytes, 8'h00};
    for (int n = 0; n < n_words; n++) begin
      w     = (n == 0) ? present : $urandom;
      w[31] = (n < n_words - 1);
      for (int k = 0; k < 4; k++) pkt_bytes = {pkt_bytes, w[8*k +: 8]};
    end
    for (int b = 0; b < NUM_FLD; b++) begin
      if (present[b] && FIELD_SIZE[b] != 0) begin
        while (pkt_bytes.size() % FIELD_ALIGN[b] != 0) pkt_bytes = {pkt_bytes, 8'($urandom)};
        for (int k = 0; k < FIELD_SIZE[b]; k++) begin
          if (b == CH_FIELD && k < 2) pkt_bytes = {pkt_bytes, freq[8*k +: 8]};
          else if (b == SIG_FIELD) pkt_bytes = {pkt_bytes, sig};
          else pkt_bytes = {pkt_bytes, 8'($urandom)};
        end
      end
    end
    set_hdr_len(pkt_bytes.size());
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(2412, 2472));
      1:       return 16'($urandom_range(5000, 5900));
      2:       return 16'($urandom);
      default: return FREQ_EDGES[$urandom_range(14)];
    endcase
  endfunction

  task automatic random_packet();
    logic [31:0] present;
    int unsigned hl;
    if ($urandom_range(99) < 20) begin
      pkt_bytes.delete();
      add_payload($urandom_range(1, 24));
      if (pkt_bytes.size() >= 4 && $urandom_range(1) == 1)
        set_hdr_len($urandom_range(0, pkt_bytes.size() + 2));
    end else begin
      present = ($urandom & $urandom & 32'h003F_FFFF) | ($urandom & 32'h7FC0_0000);
      if ($urandom_range(9) < 7) present[CH_FIELD] = 1'b1;
      if ($urandom_range(9) < 7) present[SIG_FIELD] = 1'b1;
      build_header(present, $urandom_range(1, 3), pick_freq(), 8'($urandom));
      hl = pkt_bytes.size();
      case ($urandom_range(9))
        0:       set_hdr_len($urandom_range(0, hl - 1));
        1:       set_hdr_len(hl + $urandom_range(1, 8));
        default: ;
      endcase
      add_payload($urandom_range(0, 6));
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(1, 6)) if (pkt_bytes.size() > 1) void'(pkt_bytes.pop_back());
      end
    end
  endtask

  task automatic test_invalid_headers();
    pkt_bytes.delete();
    add_payload(1);
    send_pkt();
    pkt_bytes.delete();
    add_payload(3);
    send_pkt();
    build_header(32'h0, 1, 16'd0, 8'h00);
    void'(pkt_bytes.pop_back());
    send_pkt();
    build_header(32'h0, 1, 16'd0, 8'h00);
    set_hdr_len(7);
    add_payload(4);
    send_pkt();
    build_header(32'h0, 1, 16'd0, 8'h00);
    set_hdr_len(0);
    add_payload(4);
    send_pkt();
    build_header(32'h28, 1, 16'd2437, 8'hC0);
    add_payload(2);
    set_hdr_len(pkt_bytes.size() + 1);
    send_pkt();
    build_header(32'h28, 1, 16'd2437, 8'hC0);
    set_hdr_len(16'hFFFF);
    send_pkt();
    wait_drain();
  endtask

  task automatic test_field_walk();
    build_header(32'h0, 1, 16'd0, 8'h00);
    send_pkt();
    foreach (FREQ_EDGES[n]) begin
      build_header(32'h28, 1, FREQ_EDGES[n], (n % 2 == 0) ? 8'h80 : 8'h7F);
      add_payload(n % 3);
      send_pkt();
    end
    build_header(32'h20, 1, 16'd0, 8'hFF);
    send_pkt();
    build_header(32'h08, 1, 16'd5745, 8'h00);
    send_pkt();
    // timestamp alignment, the zero-size bit and every known bit
    build_header(32'h0004_0029, 1, 16'd2462, 8'hB5);
    send_pkt();
    build_header(32'h003F_FFFF, 3, 16'd5320, 8'hA1);
    add_payload(3);
    send_pkt();
    build_header(32'h7FFF_FFFF, 2, 16'd2484, 8'h01);
    send_pkt();
    // field overrun: signal cut off, then channel cut off
    build_header(32'h28, 1, 16'd2442, 8'hD8);
    set_hdr_len(12);
    add_payload(4);
    send_pkt();
    build_header(32'h28, 1, 16'd2442, 8'hD8);
    set_hdr_len(10);
    add_payload(4);
    send_pkt();
    // extension flag set but no room for another word
    build_header(32'h0, 2, 16'd0, 8'h00);
    set_hdr_len(8);
    send_pkt();
    wait_drain();
  endtask

  task automatic test_backpressure();
    rx_hold_req = HOLD_CYCLES;
    repeat (10) begin
      build_header(32'h20, 1, 16'd0, 8'($urandom));
      add_payload(1);
      send_pkt();
    end
    wait_drain();
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned byte_goal, pkt_goal;
    byte_goal = n_bytes + n;
    pkt_goal  = n_packets + 2;
    while (n_bytes < byte_goal || n_packets < pkt_goal) begin
      random_packet();
      send_pkt();
    end
    wait_drain();
  endtask

  initial begin
    clear_parser();
    tx_idle_pct = 15;
    rx_idle_pct = 53;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_invalid_headers();
    test_field_walk();
    test_random(90);

    tx_idle_pct = 53;
    rx_idle_pct = 15;
    test_backpressure();
    test_random(90);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(90);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d packets (%0d bytes) and %0d checked results,", n_packets,
             n_bytes, n_checked);
    $display("  incl. bad lengths, field overruns, extension words and a long output stall.");
    if (mismatches == 0 && hdr_summary_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing", $time, mismatches,
               hdr_summary_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rhp_pkg.sv
hw/rtl/rhp_field_pick.sv
hw/rtl/rhp_parser.sv
hw/rtl/radiotap_header_parser_top.sv
hw/rtl/rhp_checker.sv
bench/tb.sv
